### hdl/ftse_pkg.sv
`timescale 1ns / 1ps

package ftse_pkg;

   // tree geometry
   localparam int unsigned SIZE   = 1024;
   localparam int unsigned ADDR_W = $clog2(SIZE);

   // field widths
   localparam int unsigned OP_W   = 2;
   localparam int unsigned POS_W  = 11;
   localparam int unsigned AMT_W  = 32;
   localparam int unsigned SUM_W  = 64;

   // walk index must hold 2*SIZE (add walk overshoot) and end+1
   localparam int unsigned IDX_W  = (POS_W + 1 > ADDR_W + 2) ? POS_W + 1 : ADDR_W + 2;

   localparam logic [POS_W-1:0] SIZE_RESET = POS_W'(1024);

   typedef enum logic [OP_W-1:0] {
      OP_POINT_ADD = 2'd0,
      OP_PREFIX    = 2'd1,
      OP_RANGE_SUM = 2'd2,
      OP_RANGE_ADD = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      IDX_HOLD        = 3'd0,
      IDX_POS         = 3'd1,
      IDX_POS_CLAMP   = 3'd2,
      IDX_POSM1_CLAMP = 3'd3,
      IDX_END_CLAMP   = 3'd4,
      IDX_END_P1      = 3'd5,
      IDX_UP          = 3'd6,
      IDX_DOWN        = 3'd7
   } idx_src_type;

   typedef enum logic [1:0] {
      ACC_HOLD = 2'd0,
      ACC_ADD  = 2'd1,
      ACC_SUB  = 2'd2
   } acc_op_type;

   typedef enum logic [2:0] {
      JC_NEXT          = 3'd0,
      JC_ALWAYS        = 3'd1,
      JC_DISPATCH      = 3'd2,
      JC_IDX_OUT       = 3'd3,
      JC_IDX_ZERO      = 3'd4,
      JC_NOT_RANGE_ADD = 3'd5
   } jump_cond_type;

   localparam int unsigned PC_W = 5;
   typedef logic [PC_W-1:0] pc_type;

   // microprogram labels
   localparam pc_type PC_DISPATCH   = 5'd0;
   localparam pc_type PC_ADD_LOAD   = 5'd1;
   localparam pc_type PC_ADD1_TEST  = 5'd2;
   localparam pc_type PC_ADD1_WR    = 5'd3;
   localparam pc_type PC_ADD_SWITCH = 5'd4;
   localparam pc_type PC_ADD2_TEST  = 5'd5;
   localparam pc_type PC_ADD2_WR    = 5'd6;
   localparam pc_type PC_PFX_LOAD   = 5'd7;
   localparam pc_type PC_PFX_TEST   = 5'd8;
   localparam pc_type PC_PFX_ACC    = 5'd9;
   localparam pc_type PC_RS_LOAD    = 5'd10;
   localparam pc_type PC_RS_HI_TEST = 5'd11;
   localparam pc_type PC_RS_HI_ACC  = 5'd12;
   localparam pc_type PC_RS_LO_LOAD = 5'd13;
   localparam pc_type PC_RS_LO_TEST = 5'd14;
   localparam pc_type PC_RS_LO_ACC  = 5'd15;
   localparam pc_type PC_DONE       = 5'd16;

   typedef struct packed {
      idx_src_type   idx_src;
      logic          mem_rd;
      logic          mem_wr;
      acc_op_type    acc_op;
      logic          neg_delta;
      jump_cond_type jc;
      pc_type        target;
      logic          done;
   } ucode_type;

   // sequencer -> datapath
   typedef struct packed {
      ucode_type         uw;
      logic              start;
      logic              load_rsp;
      logic              clr_wr;
      logic [ADDR_W-1:0] clr_addr;
   } dp_ctl_type;

   // datapath -> sequencer
   typedef struct packed {
      op_type op;
      logic   idx_zero;
      logic   idx_out;
      logic   rsp_busy;
   } dp_stat_type;

   function automatic ucode_type uc(input idx_src_type   src,
                                    input logic          rd,
                                    input logic          wr,
                                    input acc_op_type    acc,
                                    input logic          neg,
                                    input jump_cond_type jc,
                                    input pc_type        tgt,
                                    input logic          done);
      ucode_type w;
      w.idx_src   = src;
      w.mem_rd    = rd;
      w.mem_wr    = wr;
      w.acc_op    = acc;
      w.neg_delta = neg;
      w.jc        = jc;
      w.target    = tgt;
      w.done      = done;
      return w;
   endfunction

   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type w;
      case (pc)
         PC_DISPATCH:   w = uc(IDX_HOLD, 1'b0, 1'b0, ACC_HOLD, 1'b0, JC_DISPATCH,
                               PC_DISPATCH, 1'b0);
         PC_ADD_LOAD:   w = uc(IDX_POS, 1'b0, 1'b0, ACC_HOLD, 1'b0, JC_NEXT,
                               PC_DISPATCH, 1'b0);
         PC_ADD1_TEST:  w = uc(IDX_HOLD, 1'b1, 1'b0, ACC_HOLD, 1'b0, JC_IDX_OUT,
                               PC_ADD_SWITCH, 1'b0);
         PC_ADD1_WR:    w = uc(IDX_UP, 1'b0, 1'b1, ACC_HOLD, 1'b0, JC_ALWAYS,
                               PC_ADD1_TEST, 1'b0);
         PC_ADD_SWITCH: w = uc(IDX_END_P1, 1'b0, 1'b0, ACC_HOLD, 1'b1, JC_NOT_RANGE_ADD,
                               PC_DONE, 1'b0);
         PC_ADD2_TEST:  w = uc(IDX_HOLD, 1'b1, 1'b0, ACC_HOLD, 1'b0, JC_IDX_OUT,
                               PC_DONE, 1'b0);
         PC_ADD2_WR:    w = uc(IDX_UP, 1'b0, 1'b1, ACC_HOLD, 1'b0, JC_ALWAYS,
                               PC_ADD2_TEST, 1'b0);
         PC_PFX_LOAD:   w = uc(IDX_POS_CLAMP, 1'b0, 1'b0, ACC_HOLD, 1'b0, JC_NEXT,
                               PC_DISPATCH, 1'b0);
         PC_PFX_TEST:   w = uc(IDX_HOLD, 1'b1, 1'b0, ACC_HOLD, 1'b0, JC_IDX_ZERO,
                               PC_DONE, 1'b0);
         PC_PFX_ACC:    w = uc(IDX_DOWN, 1'b0, 1'b0, ACC_ADD, 1'b0, JC_ALWAYS,
                               PC_PFX_TEST, 1'b0);
         PC_RS_LOAD:    w = uc(IDX_END_CLAMP, 1'b0, 1'b0, ACC_HOLD, 1'b0, JC_NEXT,
                               PC_DISPATCH, 1'b0);
         PC_RS_HI_TEST: w = uc(IDX_HOLD, 1'b1, 1'b0, ACC_HOLD, 1'b0, JC_IDX_ZERO,
                               PC_RS_LO_LOAD, 1'b0);
         PC_RS_HI_ACC:  w = uc(IDX_DOWN, 1'b0, 1'b0, ACC_ADD, 1'b0, JC_ALWAYS,
                               PC_RS_HI_TEST, 1'b0);
         PC_RS_LO_LOAD: w = uc(IDX_POSM1_CLAMP, 1'b0, 1'b0, ACC_HOLD, 1'b0, JC_NEXT,
                               PC_DISPATCH, 1'b0);
         PC_RS_LO_TEST: w = uc(IDX_HOLD, 1'b1, 1'b0, ACC_HOLD, 1'b0, JC_IDX_ZERO,
                               PC_DONE, 1'b0);
         PC_RS_LO_ACC:  w = uc(IDX_DOWN, 1'b0, 1'b0, ACC_SUB, 1'b0, JC_ALWAYS,
                               PC_RS_LO_TEST, 1'b0);
         PC_DONE:       w = uc(IDX_HOLD, 1'b0, 1'b0, ACC_HOLD, 1'b0, JC_NEXT,
                               PC_DISPATCH, 1'b1);
         default:       w = uc(IDX_HOLD, 1'b0, 1'b0, ACC_HOLD, 1'b0, JC_ALWAYS,
                               PC_DONE, 1'b0);
      endcase
      return w;
   endfunction

endpackage

### hdl/ftse_ifs.sv
`timescale 1ns / 1ps

interface ftse_req_if import ftse_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         op;
   logic [POS_W-1:0]        position;
   logic [POS_W-1:0]        range_end;
   logic signed [AMT_W-1:0] amount;

   modport source (output valid, op, position, range_end, amount, input ready);
   modport sink   (input valid, op, position, range_end, amount, output ready);
endinterface

interface ftse_rsp_if import ftse_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [SUM_W-1:0] sum;

   modport source (output valid, sum, input ready);
   modport sink   (input valid, sum, output ready);
endinterface

interface ftse_csr_if import ftse_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### hdl/ftse_useq.sv
`timescale 1ns / 1ps

module ftse_useq import ftse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_ctl_type  ctl
);

   typedef enum logic [2:0] {
      SQ_CLEAR = 3'b001,
      SQ_IDLE  = 3'b010,
      SQ_RUN   = 3'b100
   } seq_state_type;

   seq_state_type     state_ff, state_in;
   pc_type            pc_ff, pc_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   ucode_type         uw;
   logic              jump;
   pc_type            target;

   // branch resolution
   always_comb begin
      uw     = ucode_rom(pc_ff);
      target = uw.target;
      jump   = 1'b0;
      unique case (uw.jc)
         JC_NEXT:          jump = 1'b0;
         JC_ALWAYS:        jump = 1'b1;
         JC_DISPATCH: begin
            jump = 1'b1;
            unique case (stat.op) inside
               OP_POINT_ADD, OP_RANGE_ADD: target = PC_ADD_LOAD;
               OP_PREFIX:                  target = PC_PFX_LOAD;
               default:                    target = PC_RS_LOAD;
            endcase
         end
         JC_IDX_OUT:       jump = stat.idx_zero || stat.idx_out;
         JC_IDX_ZERO:      jump = stat.idx_zero;
         JC_NOT_RANGE_ADD: jump = (stat.op != OP_RANGE_ADD);
         default:          jump = 1'b0;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      pc_in      = pc_ff;
      clr_cnt_in = clr_cnt_ff;
      req_ready  = 1'b0;
      ctl        = '0;
      unique case (state_ff)
         SQ_CLEAR: begin
            ctl.clr_wr   = 1'b1;
            ctl.clr_addr = clr_cnt_ff;
            clr_cnt_in   = clr_cnt_ff + 1'b1;
            if (&clr_cnt_ff) begin
               state_in = SQ_IDLE;
            end
         end
         SQ_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.start = 1'b1;
               state_in  = SQ_RUN;
               pc_in     = PC_DISPATCH;
            end
         end
         SQ_RUN: begin
            if (uw.done) begin
               // hold on the done step while the output register is occupied and not being taken
               if (!stat.rsp_busy) begin
                  ctl.load_rsp = 1'b1;
                  state_in     = SQ_IDLE;
               end
            end else begin
               ctl.uw = uw;
               pc_in  = jump ? target : pc_ff + 1'b1;
            end
         end
         default: state_in = SQ_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= SQ_CLEAR;
         pc_ff      <= PC_DISPATCH;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pc_ff      <= pc_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      state_ff == SQ_RUN |-> pc_ff <= PC_DONE)
      else $error("program counter left the microprogram");

   a_start_enters_dispatch: assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> state_ff == SQ_RUN && pc_ff == PC_DISPATCH)
      else $error("accepted beat did not enter dispatch");

endmodule

### hdl/ftse_datapath.sv
`timescale 1ns / 1ps

module ftse_datapath import ftse_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  dp_ctl_type              ctl,
   output dp_stat_type             stat,
   input  logic [OP_W-1:0]         req_op,
   input  logic [POS_W-1:0]        req_position,
   input  logic [POS_W-1:0]        req_range_end,
   input  logic signed [AMT_W-1:0] req_amount,
   ftse_rsp_if.source              rsp,
   ftse_csr_if.sink                csr
);

   logic [SUM_W-1:0]  tree_mem [SIZE];

   op_type            op_ff, op_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  end_ff, end_in;
   logic [SUM_W-1:0]  delta_ff, delta_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic [SUM_W-1:0]  rdata_ff;
   logic [POS_W-1:0]  size_ff, size_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  rsp_sum_ff, rsp_sum_in;

   logic [IDX_W-1:0]  n_act;
   logic [IDX_W-1:0]  lowbit;
   logic [IDX_W-1:0]  idx_dec;
   logic [IDX_W-1:0]  pos_m1;
   logic [ADDR_W-1:0] node_addr;
   logic              mem_we;
   logic [ADDR_W-1:0] wr_addr;
   logic [SUM_W-1:0]  wr_data;

   function automatic logic [IDX_W-1:0] clamp(input logic [IDX_W-1:0] x,
                                              input logic [IDX_W-1:0] lim);
      return (x > lim) ? lim : x;
   endfunction

   always_comb begin
      n_act = (IDX_W'(size_ff) > IDX_W'(SIZE)) ? IDX_W'(SIZE) : IDX_W'(size_ff);
      lowbit    = idx_ff & (~idx_ff + 1'b1);
      idx_dec   = idx_ff - 1'b1;
      node_addr = idx_dec[ADDR_W-1:0];
      pos_m1    = IDX_W'(pos_ff) - 1'b1;
   end

   always_comb begin
      unique case (ctl.uw.idx_src)
         IDX_HOLD:        idx_in = idx_ff;
         IDX_POS:         idx_in = IDX_W'(pos_ff);
         IDX_POS_CLAMP:   idx_in = clamp(IDX_W'(pos_ff), n_act);
         IDX_POSM1_CLAMP: idx_in = (pos_ff == '0) ? '0 : clamp(pos_m1, n_act);
         IDX_END_CLAMP:   idx_in = clamp(IDX_W'(end_ff), n_act);
         IDX_END_P1:      idx_in = IDX_W'(end_ff) + 1'b1;
         IDX_UP:          idx_in = idx_ff + lowbit;
         IDX_DOWN:        idx_in = idx_ff - lowbit;
         default:         idx_in = idx_ff;
      endcase
   end

   always_comb begin
      op_in    = op_ff;
      pos_in   = pos_ff;
      end_in   = end_ff;
      delta_in = delta_ff;
      acc_in   = acc_ff;
      if (ctl.start) begin
         op_in    = op_type'(req_op);
         pos_in   = req_position;
         end_in   = req_range_end;
         delta_in = {{(SUM_W-AMT_W){req_amount[AMT_W-1]}}, req_amount};
         acc_in   = '0;
      end else begin
         if (ctl.uw.neg_delta) begin
            delta_in = ~delta_ff + 1'b1;
         end
         case (ctl.uw.acc_op)
            ACC_ADD: acc_in = acc_ff + rdata_ff;
            ACC_SUB: acc_in = acc_ff - rdata_ff;
            default: acc_in = acc_ff;
         endcase
      end
   end

   // one-entry output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sum_in   = rsp_sum_ff;
      if (ctl.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_sum_in   = acc_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      size_in = csr.valid ? csr.data : size_ff;
   end

   always_comb begin
      mem_we  = ctl.clr_wr || ctl.uw.mem_wr;
      wr_addr = ctl.clr_wr ? ctl.clr_addr : node_addr;
      wr_data = ctl.clr_wr ? '0 : rdata_ff + delta_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tree_mem[wr_addr] <= wr_data;
      end
      if (ctl.uw.mem_rd) begin
         rdata_ff <= tree_mem[node_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         size_ff      <= SIZE_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         size_ff      <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      pos_ff     <= pos_in;
      end_ff     <= end_in;
      delta_ff   <= delta_in;
      idx_ff     <= idx_in;
      acc_ff     <= acc_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   assign stat.op       = op_ff;
   assign stat.idx_zero = (idx_ff == '0);
   assign stat.idx_out  = (idx_ff > n_act);
   assign stat.rsp_busy = rsp_valid_ff && !rsp.ready;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.sum   = $signed(rsp_sum_ff);
   assign csr.ready = 1'b1;

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ctl.uw.mem_wr |-> idx_ff != '0 && idx_ff <= n_act && !ctl.clr_wr)
      else $error("tree write outside the active node range");

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.load_rsp |-> !(rsp_valid_ff && !rsp.ready))
      else $error("result register overwritten while stalled");

endmodule

### hdl/fenwick_tree_sum_engine_core.sv
`timescale 1ns / 1ps

// Binary indexed tree of 64-bit wrapping sums over positions 1..size_in_use.
// req_bus: one beat per request (op, position, range_end, amount). Ops are
//   point add, prefix sum, range sum and range add; every request yields
//   exactly one rsp_bus beat, zero for the add ops.
// csr_bus: writes size_in_use (reset 1024, clamped to 1024 internally);
//   always ready, write only while no request is in flight.
// A walk visits k tree nodes (<= 11). Each node takes a registered read of
//   the single node memory, then the accumulate or read-modify-write. One
//   request is worked on at a time; the next beat is taken in the idle
//   cycle right after the result is loaded.
// Reset: a clearing pass zeroes the 1024-entry node memory, one entry per
//   cycle; req_bus.ready stays low until the pass is over.
// Stall: the result sits in a one-beat output register; a new request is
//   accepted while it waits, and the sequencer holds on its final step until
//   the register frees up.
module fenwick_tree_sum_engine_core import ftse_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ftse_req_if.sink   req_bus,
   ftse_rsp_if.source rsp_bus,
   ftse_csr_if.sink   csr_bus
);

   dp_ctl_type  ctl;
   dp_stat_type stat;
   logic        req_ready;

   // microprogram sequencer: step counter, control ROM, branch logic
   ftse_useq u_useq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // node memory, walk index, accumulator and result register
   ftse_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .stat          (stat),
      .req_op        (req_bus.op),
      .req_position  (req_bus.position),
      .req_range_end (req_bus.range_end),
      .req_amount    (req_bus.amount),
      .rsp           (rsp_bus),
      .csr           (csr_bus)
   );

   assign req_bus.ready = req_ready;

endmodule
